// ===== rtl/mlft_pkg.sv =====
// Shared types and constants for the MAC learning forwarding table.
// Used by the cells, the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mlft_pkg;

    localparam int PORT_COUNT    = 4;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int MAC_W  = 48;
    localparam int PORT_W = 2;
    localparam int MASK_W = 4;

    localparam logic [MAC_W-1:0]  MAC_BROADCAST = {MAC_W{1'b1}};
    // ports that exist on this switch, limited to the mask width
    localparam logic [MASK_W-1:0] PORTS_PRESENT =
        MASK_W'((64'd1 << PORT_COUNT) - 64'd1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_CONNECTED = 1'b1;

    typedef enum logic [2:0] {
        DEC_BROADCAST  = 3'd0,
        DEC_UNICAST    = 3'd1,
        DEC_FLOOD      = 3'd2,
        DEC_DROPPED    = 3'd3,
        DEC_DELETED    = 3'd4,
        DEC_DELETE_MISS = 3'd5
    } decision_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // search result token that walks down the row of cells
    typedef struct packed {
        logic [IDX_W-1:0]  pos;
        logic              src_hit;
        logic [IDX_W-1:0]  src_idx;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
    } probe_t;

    // table write issued by the controller
    typedef struct packed {
        logic                     learn;
        logic                     clear;
        logic [TABLE_ENTRIES-1:0] sel;
        logic [MAC_W-1:0]         mac;
        logic [PORT_W-1:0]        port;
    } tbl_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mac_learning_forward_table.sv =====
// Top level of the MAC learning forwarding table: config registers,
// sequencer and the row of table cells. Depends on mlft_pkg, mlft_cell, mlft_ctrl.
//
//  channel | ports              | carries
//  --------+--------------------+---------------------------------------------
//  input   | s_tvalid/s_tready  | one frame header or delete request
//  result  | m_tvalid/m_tready  | one forwarding decision per input transfer
//  config  | cfg_wr_en          | port enable / connected masks, no read-back
//
// After an item's transfer the search token walks the row of TABLE_ENTRIES cells one
// cell per cycle, then the decide state decides, updates the table and registers the
// result that drives m_tvalid. A new item is taken only once the sequencer is idle
// again after the decide state of the last one. Reset clears all valid bits at once,
// no clearing pass. A result held by m_tready low delays only the next item's decide.
`timescale 1ns / 1ps
`default_nettype none

module mac_learning_forward_table (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // in_port[1:0], src_mac[49:2], dst_mac[97:50]
    input  wire logic [0:0]   s_tuser,   // action[0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,   // forward_mask[3:0], decision[6:4],
                                         // learned[7], learn_failed[8]
    input  wire logic         cfg_wr_en,
    input  wire logic [mlft_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mlft_pkg::MASK_W-1:0]    cfg_wdata
);
    import mlft_pkg::*;

    logic [MASK_W-1:0] enable_reg;
    logic [MASK_W-1:0] connected_reg;
    logic [MAC_W-1:0]  key_src;
    logic [MAC_W-1:0]  key_dst;
    tbl_wr_t           wr;
    probe_t            chain [TABLE_ENTRIES+1];
    logic [MASK_W-1:0] out_mask;
    decision_t         out_dec;
    logic              out_learned;
    logic              out_failed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= MASK_W'(15);
            connected_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PORT_ENABLE:    enable_reg    <= cfg_wdata;
                CFG_PORT_CONNECTED: connected_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mlft_ctrl u_ctrl (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (s_tvalid),
        .in_ready            (s_tready),
        .in_action           (s_tuser[0]),
        .in_port             (s_tdata[1:0]),
        .in_src_mac          (s_tdata[49:2]),
        .in_dst_mac          (s_tdata[97:50]),
        .port_enable_mask    (enable_reg),
        .port_connected_mask (connected_reg),
        .key_src_mac         (key_src),
        .key_dst_mac         (key_dst),
        .probe_last          (chain[TABLE_ENTRIES]),
        .wr                  (wr),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_forward_mask    (out_mask),
        .out_decision        (out_dec),
        .out_learned         (out_learned),
        .out_learn_failed    (out_failed)
    );

    assign chain[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        mlft_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1]),
            .src_mac   (key_src),
            .dst_mac   (key_dst),
            .wr        (wr),
            .wr_sel    (wr.sel[i])
        );
    end

    assign m_tdata = {7'd0, out_failed, out_learned, out_dec, out_mask};

endmodule

`default_nettype wire

// ===== rtl/mlft_cell.sv =====
// One table entry of the forwarding table plus its stage of the search row.
// Depends on mlft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlft_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mlft_pkg::probe_t           probe_in,
    output mlft_pkg::probe_t                probe_out,
    input  wire logic [mlft_pkg::MAC_W-1:0] src_mac,
    input  wire logic [mlft_pkg::MAC_W-1:0] dst_mac,
    input  wire mlft_pkg::tbl_wr_t          wr,
    input  wire logic                       wr_sel
);
    import mlft_pkg::*;

    logic              valid_reg;
    logic [MAC_W-1:0]  addr_reg;
    logic [PORT_W-1:0] port_reg;
    probe_t            probe_reg;
    probe_t            probe_next;

    always_comb begin
        probe_next     = probe_in;
        probe_next.pos = probe_in.pos + IDX_W'(1);
        if (!probe_in.src_hit && valid_reg && addr_reg == src_mac) begin
            probe_next.src_hit = 1'b1;
            probe_next.src_idx = probe_in.pos;
        end
        if (!probe_in.free_found && !valid_reg) begin
            probe_next.free_found = 1'b1;
            probe_next.free_idx   = probe_in.pos;
        end
        if (!probe_in.dst_hit && valid_reg && addr_reg == dst_mac) begin
            probe_next.dst_hit  = 1'b1;
            probe_next.dst_port = port_reg;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_sel && wr.learn) begin
            valid_reg <= 1'b1;
        end else if (wr_sel && wr.clear) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_sel && wr.learn) begin
            addr_reg <= wr.mac;
            port_reg <= wr.port;
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ===== rtl/mlft_ctrl.sv =====
// Item sequencer: holds the item, times the search, decides, learns and deletes.
// Depends on mlft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlft_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_action,
    input  wire logic [mlft_pkg::PORT_W-1:0] in_port,
    input  wire logic [mlft_pkg::MAC_W-1:0]  in_src_mac,
    input  wire logic [mlft_pkg::MAC_W-1:0]  in_dst_mac,
    input  wire logic [mlft_pkg::MASK_W-1:0] port_enable_mask,
    input  wire logic [mlft_pkg::MASK_W-1:0] port_connected_mask,
    output logic [mlft_pkg::MAC_W-1:0]       key_src_mac,
    output logic [mlft_pkg::MAC_W-1:0]       key_dst_mac,
    input  wire mlft_pkg::probe_t            probe_last,
    output mlft_pkg::tbl_wr_t                wr,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mlft_pkg::MASK_W-1:0]      out_forward_mask,
    output mlft_pkg::decision_t              out_decision,
    output logic                             out_learned,
    output logic                             out_learn_failed
);
    import mlft_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              action_reg;
    logic [PORT_W-1:0] port_reg;
    logic [MAC_W-1:0]  src_reg;
    logic [MAC_W-1:0]  dst_reg;

    logic              m_valid_reg, m_valid_next;
    logic [MASK_W-1:0] m_mask_reg, m_mask_next;
    decision_t         m_dec_reg, m_dec_next;
    logic              m_learned_reg, m_learned_next;
    logic              m_failed_reg, m_failed_next;

    logic              accept;
    logic              emit;
    logic [MASK_W-1:0] usable;
    logic [MASK_W-1:0] flood;
    logic              learn;
    logic              self_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] egress;
    logic [TABLE_ENTRIES-1:0] one;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign one      = {{(TABLE_ENTRIES-1){1'b0}}, 1'b1};

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        m_mask_next    = m_mask_reg;
        m_dec_next     = m_dec_reg;
        m_learned_next = m_learned_reg;
        m_failed_next  = m_failed_reg;
        emit           = 1'b0;

        usable   = port_enable_mask & port_connected_mask & PORTS_PRESENT;
        flood    = usable & ~(MASK_W'(1) << port_reg);
        learn    = !action_reg && !probe_last.src_hit && probe_last.free_found;
        // a freshly learned source is not yet seen by the search
        self_hit = learn && (dst_reg == src_reg);
        dst_hit  = probe_last.dst_hit || self_hit;
        egress   = self_hit ? port_reg : probe_last.dst_port;

        wr       = '0;
        wr.mac   = src_reg;
        wr.port  = port_reg;

        if (out_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!m_valid_reg || out_ready) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next   = 1'b1;
            m_mask_next    = '0;
            m_learned_next = 1'b0;
            m_failed_next  = 1'b0;
            if (action_reg) begin
                if (probe_last.src_hit) begin
                    wr.clear   = 1'b1;
                    wr.sel     = one << probe_last.src_idx;
                    m_dec_next = DEC_DELETED;
                end else begin
                    m_dec_next = DEC_DELETE_MISS;
                end
            end else begin
                if (learn) begin
                    wr.learn = 1'b1;
                    wr.sel   = one << probe_last.free_idx;
                end
                m_learned_next = learn;
                m_failed_next  = !probe_last.src_hit && !probe_last.free_found;
                if (dst_reg == MAC_BROADCAST) begin
                    m_mask_next = flood;
                    m_dec_next  = DEC_BROADCAST;
                end else if (!dst_hit) begin
                    m_mask_next = flood;
                    m_dec_next  = DEC_FLOOD;
                end else if (usable[egress] && egress != port_reg) begin
                    m_mask_next = MASK_W'(1) << egress;
                    m_dec_next  = DEC_UNICAST;
                end else begin
                    m_dec_next  = DEC_DROPPED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= in_action;
            port_reg   <= in_port;
            src_reg    <= in_src_mac;
            dst_reg    <= in_dst_mac;
        end
        m_mask_reg    <= m_mask_next;
        m_dec_reg     <= m_dec_next;
        m_learned_reg <= m_learned_next;
        m_failed_reg  <= m_failed_next;
    end

    assign key_src_mac      = src_reg;
    assign key_dst_mac      = dst_reg;
    assign out_valid        = m_valid_reg;
    assign out_forward_mask = m_mask_reg;
    assign out_decision     = m_dec_reg;
    assign out_learned      = m_learned_reg;
    assign out_learn_failed = m_failed_reg;

endmodule

`default_nettype wire

// ===== rtl/mlft_checker.sv =====
// Port-level checks for mac_learning_forward_table, bound to the top level.
// Depends on mlft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlft_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import mlft_pkg::*;

    // a stalled result transfer keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no input transfer right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_dec_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:4] != 3'd6 && m_tdata[6:4] != 3'd7)
        else $error("decision code out of range");

    // delete results carry no egress and no learning flags
    a_delete_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:4] == DEC_DELETED || m_tdata[6:4] == DEC_DELETE_MISS)
        |-> m_tdata[8:0] == {2'b00, m_tdata[6:4], 4'b0000})
        else $error("delete result has mask or learn flags");

    a_learn_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[7] && m_tdata[8]))
        else $error("learned and learn_failed both set");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
